FILE: rtl/dsten_pkg.sv
// Shared types and constants for the axis diffusion stencil.
package dsten_pkg;

  localparam int unsigned MAX_GRID    = 63;
  localparam int unsigned VALUE_BITS  = 24;
  localparam int unsigned COEFF_BITS  = 16;
  localparam int unsigned IDX_BITS    = 6;
  localparam int unsigned FRAC_SHIFT  = COEFF_BITS - 2;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_BITS   = 2;

  // Product widths: center term and neighbor-sum term, then their sum
  localparam int unsigned PC_BITS  = VALUE_BITS + COEFF_BITS;
  localparam int unsigned PN_BITS  = VALUE_BITS + 1 + COEFF_BITS;
  localparam int unsigned SUM_BITS = PN_BITS + 1;
  localparam int unsigned SH_BITS  = SUM_BITS - FRAC_SHIFT;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_COEFF_CENTER   = 2'd0,
    REG_COEFF_NEIGHBOR = 2'd1,
    REG_DIRECTION      = 2'd2,
    REG_GRID_SIZE      = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    DIR_ROW = 1'b0,
    DIR_COL = 1'b1
  } dir_e;

  typedef struct packed {
    logic signed [COEFF_BITS-1:0] coeff_center;
    logic signed [COEFF_BITS-1:0] coeff_neighbor;
    dir_e                         direction;
    logic [IDX_BITS-1:0]          grid_size;
  } cfg_t;

  // One stencil job handed from the front to the back
  typedef struct packed {
    logic signed [VALUE_BITS-1:0] prior;
    logic signed [VALUE_BITS-1:0] center;
    logic signed [VALUE_BITS-1:0] after;
    logic [IDX_BITS-1:0]          row;
    logic [IDX_BITS-1:0]          col;
    logic                         done;
  } op_t;

endpackage

FILE: rtl/dsten_fifo.sv
// Small job queue between the front and the back of the stencil.
module dsten_fifo
  import dsten_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  push_op_i,
  input  logic pop_i,
  output op_t  pop_op_o,
  output logic full_o,
  output logic empty_o
);

  op_t                  mem_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_BITS:0]   count_q, count_d;
  logic                 do_push, do_pop;

  assign full_o   = (count_q == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign empty_o  = (count_q == '0);
  assign do_push  = push_i && !full_o;
  assign do_pop   = pop_i && !empty_o;
  assign pop_op_o = mem_q[rd_ptr_q];

  // Pointer and fill count
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

endmodule

FILE: rtl/dsten_front.sv
// Front end: cell intake, line stores, neighbor gathering and end-of-frame flush.
module dsten_front
  import dsten_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cfg_t                         cfg_i,
  input  logic                         clr_i,
  input  logic signed [VALUE_BITS-1:0] cell_value_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         q_full_i,
  output logic                         q_push_o,
  output op_t                          q_op_o
);

  // Line stores for column mode
  logic [VALUE_BITS-1:0] prev_mem [MAX_GRID];
  logic [VALUE_BITS-1:0] pend_mem [MAX_GRID];

  logic [IDX_BITS-1:0] row_q, row_d, col_q, col_d;
  logic [IDX_BITS-1:0] edge_m1;
  logic                a_last_row, a_last_col;
  logic                a_cell, a_flush, a_load;
  logic [IDX_BITS-1:0] rd_addr;

  // Flush sequencer
  logic                flush_q, flush_d;
  logic [IDX_BITS-1:0] fidx_q, fidx_d;

  // Stage B: gathered neighbors
  logic                         b_valid_q, b_valid_d;
  logic                         b_flush_q;
  logic signed [VALUE_BITS-1:0] b_cur_q;
  logic [IDX_BITS-1:0]          b_row_q, b_col_q;
  logic                         b_lastr_q, b_lastc_q;
  logic signed [VALUE_BITS-1:0] prev_rd_q, pend_rd_q;

  // Row-mode window
  logic signed [VALUE_BITS-1:0] left_q, pendc_q;

  // Second result of a row end in row mode
  logic tail_v_q, tail_v_d;
  op_t  tail_q;

  logic b_has_op, b_mk_tail, b_trig, b_go, b_free;
  op_t  b_op, tail_op;

  // Effective grid edge minus one, small grids clamp to two
  assign edge_m1 = (cfg_i.grid_size < IDX_BITS'(2)) ? IDX_BITS'(1)
                                                     : cfg_i.grid_size - 1'b1;

  assign a_last_row = (row_q == edge_m1);
  assign a_last_col = (col_q == edge_m1);

  // Stage B job formation
  always_comb begin
    b_op      = '0;
    tail_op   = '0;
    b_has_op  = 1'b0;
    b_mk_tail = 1'b0;
    if (b_flush_q) begin
      b_has_op  = 1'b1;
      b_op      = '{prior: prev_rd_q, center: pend_rd_q, after: '0,
                    row: b_row_q, col: b_col_q, done: b_lastc_q};
    end else if (cfg_i.direction == DIR_ROW) begin
      b_has_op  = (b_col_q != '0);
      b_mk_tail = b_lastc_q;
      b_op      = '{prior: left_q, center: pendc_q, after: b_cur_q,
                    row: b_row_q, col: b_col_q - 1'b1, done: 1'b0};
      tail_op   = '{prior: (b_col_q == '0) ? '0 : pendc_q, center: b_cur_q,
                    after: '0, row: b_row_q, col: b_col_q, done: b_lastr_q};
    end else begin
      b_has_op  = (b_row_q != '0);
      b_op      = '{prior: prev_rd_q, center: pend_rd_q, after: b_cur_q,
                    row: b_row_q - 1'b1, col: b_col_q, done: 1'b0};
    end
  end

  assign b_trig = b_valid_q && !b_flush_q && (cfg_i.direction == DIR_COL)
                  && b_lastr_q && b_lastc_q;
  assign b_go   = b_valid_q && (!b_has_op || (!tail_v_q && !q_full_i));
  assign b_free = !b_valid_q || b_go;

  // Intake: held off while the last row flushes
  assign in_ready_o = !flush_q && b_free && !b_trig;
  assign a_cell     = in_valid_i && in_ready_o;
  assign a_flush    = flush_q && b_free;
  assign a_load     = a_cell || a_flush;
  assign rd_addr    = flush_q ? fidx_q : col_q;

  // Queue write: a waiting tail goes first
  assign q_push_o = (tail_v_q && !q_full_i) || (b_go && b_has_op);
  assign q_op_o   = tail_v_q ? tail_q : b_op;

  // Raster position, flush index and control next state
  always_comb begin
    row_d     = row_q;
    col_d     = col_q;
    flush_d   = flush_q;
    fidx_d    = fidx_q;
    b_valid_d = b_valid_q;
    tail_v_d  = tail_v_q;
    if (a_cell) begin
      if (a_last_col) begin
        col_d = '0;
        row_d = a_last_row ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
    if (clr_i) begin
      row_d = '0;
      col_d = '0;
    end
    if (b_go && b_trig) begin
      flush_d = 1'b1;
      fidx_d  = '0;
    end else if (a_flush) begin
      flush_d = (fidx_q != edge_m1);
      fidx_d  = fidx_q + 1'b1;
    end
    if (a_load) begin
      b_valid_d = 1'b1;
    end else if (b_go) begin
      b_valid_d = 1'b0;
    end
    if (b_go && b_mk_tail) begin
      tail_v_d = 1'b1;
    end else if (tail_v_q && !q_full_i) begin
      tail_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q     <= '0;
      col_q     <= '0;
      flush_q   <= 1'b0;
      fidx_q    <= '0;
      b_valid_q <= 1'b0;
      tail_v_q  <= 1'b0;
    end else begin
      row_q     <= row_d;
      col_q     <= col_d;
      flush_q   <= flush_d;
      fidx_q    <= fidx_d;
      b_valid_q <= b_valid_d;
      tail_v_q  <= tail_v_d;
    end
  end

  // Stage B payload
  always_ff @(posedge clk_i) begin
    if (a_load) begin
      b_flush_q <= a_flush;
      b_cur_q   <= cell_value_i;
      b_row_q   <= a_flush ? edge_m1 : row_q;
      b_col_q   <= a_flush ? fidx_q : col_q;
      b_lastr_q <= a_flush ? 1'b1 : a_last_row;
      b_lastc_q <= a_flush ? (fidx_q == edge_m1) : a_last_col;
    end
    if (b_go && b_mk_tail) begin
      tail_q <= tail_op;
    end
    if (b_go && !b_flush_q && (cfg_i.direction == DIR_ROW)) begin
      left_q  <= (b_col_q == '0) ? '0 : pendc_q;
      pendc_q <= b_cur_q;
    end
  end

  // Line store access: read on load, update when a column-mode cell retires
  always_ff @(posedge clk_i) begin
    if (a_load) begin
      prev_rd_q <= $signed(prev_mem[rd_addr]);
      pend_rd_q <= $signed(pend_mem[rd_addr]);
    end
    if (b_go && !b_flush_q && (cfg_i.direction == DIR_COL)) begin
      prev_mem[b_col_q] <= (b_row_q == '0) ? '0 : pend_rd_q;
      pend_mem[b_col_q] <= b_cur_q;
    end
  end

endmodule

FILE: rtl/dsten_back.sv
// Back end: weighted sum, rounding, saturation and the output register.
module dsten_back
  import dsten_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cfg_t                         cfg_i,
  input  logic                         q_empty_i,
  input  op_t                          q_op_i,
  output logic                         q_pop_o,
  output logic signed [VALUE_BITS-1:0] new_value_o,
  output logic [IDX_BITS-1:0]          out_row_o,
  output logic [IDX_BITS-1:0]          out_col_o,
  output logic                         frame_done_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i
);

  logic                         adv;
  logic signed [VALUE_BITS:0]   nb_sum;
  logic signed [PC_BITS-1:0]    pc_d, pc_q;
  logic signed [PN_BITS-1:0]    pn_d, pn_q;
  logic                         s1_v_q;
  logic [IDX_BITS-1:0]          s1_row_q, s1_col_q;
  logic                         s1_done_q;
  logic signed [SUM_BITS-1:0]   sum;
  logic signed [SH_BITS-1:0]    sh;
  logic signed [VALUE_BITS-1:0] sat;
  logic                         ovf_hi, ovf_lo;
  logic                         out_valid_q;
  logic signed [VALUE_BITS-1:0] val_q;
  logic [IDX_BITS-1:0]          row_q, col_q;
  logic                         done_q;

  // Whole pipe moves unless the output holds an untaken result
  assign adv     = !out_valid_q || out_ready_i;
  assign q_pop_o = adv && !q_empty_i;

  // Stage 1: products
  assign nb_sum = q_op_i.prior + q_op_i.after;
  assign pc_d   = q_op_i.center * cfg_i.coeff_center;
  assign pn_d   = nb_sum * cfg_i.coeff_neighbor;

  // Stage 2: round half up, drop fraction, clamp to value range
  assign sum    = pc_q + pn_q + SUM_BITS'(1 << (FRAC_SHIFT - 1));
  assign sh     = sum[SUM_BITS-1:FRAC_SHIFT];
  assign ovf_hi = !sh[SH_BITS-1] && (|sh[SH_BITS-2:VALUE_BITS-1]);
  assign ovf_lo = sh[SH_BITS-1] && !(&sh[SH_BITS-2:VALUE_BITS-1]);

  always_comb begin
    sat = sh[VALUE_BITS-1:0];
    if (ovf_hi) begin
      sat = {1'b0, {(VALUE_BITS-1){1'b1}}};
    end else if (ovf_lo) begin
      sat = {1'b1, {(VALUE_BITS-1){1'b0}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_v_q      <= q_pop_o;
      out_valid_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pc_q      <= pc_d;
      pn_q      <= pn_d;
      s1_row_q  <= q_op_i.row;
      s1_col_q  <= q_op_i.col;
      s1_done_q <= q_op_i.done;
      val_q     <= sat;
      row_q     <= s1_row_q;
      col_q     <= s1_col_q;
      done_q    <= s1_done_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign new_value_o  = val_q;
  assign out_row_o    = row_q;
  assign out_col_o    = col_q;
  assign frame_done_o = done_q;

endmodule

FILE: rtl/axis_diffusion_stencil.sv
// Top level of the axis diffusion stencil: configuration registers and the datapath.
//
// Cells of one square frame enter in raster order on the in_valid_i/in_ready_o
// channel (cell_value_i, signed Q12.12). Each result leaves on out_valid_o/
// out_ready_i with its value, row, column and a frame_done flag on the frame's
// last result. Registers are written through cfg_we_i/cfg_idx_i/cfg_data_i; the
// user must write them only while the block is idle, which the block does not
// enforce; a direction or grid_size write restarts the frame. Row mode: a cell's
// result follows once its right neighbor is taken; the row end yields two results.
// Column mode: results lag one row, and the frame's last cell starts a flush of the
// last row, during which intake is held off. A result passes the gather stage
// (loaded at the cell transfer), the job queue, the product stage and the output
// register; the second result of a row end waits in a tail register and is queued
// after the first. Throughput is one cell per cycle while the queue has room; column
// mode adds a flush per frame, set by the single read port of the line stores.
// A four-entry job queue separates intake from the arithmetic, so a stalled
// receiver freezes only the back end until the queue fills; intake then stops.
// Reset clears all control state and loads the register reset values; the line
// stores need no clearing since each frame writes an entry before using it.
module axis_diffusion_stencil
  import dsten_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [COEFF_BITS-1:0]        cfg_data_i,
  input  logic signed [VALUE_BITS-1:0] cell_value_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  output logic signed [VALUE_BITS-1:0] new_value_o,
  output logic [IDX_BITS-1:0]          out_row_o,
  output logic [IDX_BITS-1:0]          out_col_o,
  output logic                         frame_done_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i
);

  cfg_t cfg_q, cfg_d;
  logic clr;
  logic q_push, q_pop, q_full, q_empty;
  op_t  q_push_op, q_pop_op;

  // Register writes
  always_comb begin
    cfg_d = cfg_q;
    clr   = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_COEFF_CENTER:   cfg_d.coeff_center   = cfg_data_i;
        REG_COEFF_NEIGHBOR: cfg_d.coeff_neighbor = cfg_data_i;
        REG_DIRECTION: begin
          cfg_d.direction = dir_e'(cfg_data_i[0]);
          clr             = 1'b1;
        end
        REG_GRID_SIZE: begin
          cfg_d.grid_size = cfg_data_i[IDX_BITS-1:0];
          clr             = 1'b1;
        end
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coeff_center   <= COEFF_BITS'(16384);
      cfg_q.coeff_neighbor <= '0;
      cfg_q.direction      <= DIR_ROW;
      cfg_q.grid_size      <= IDX_BITS'(32);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  dsten_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .clr_i        (clr),
    .cell_value_i (cell_value_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_op_o       (q_push_op)
  );

  dsten_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .push_op_i (q_push_op),
    .pop_i     (q_pop),
    .pop_op_o  (q_pop_op),
    .full_o    (q_full),
    .empty_o   (q_empty)
  );

  dsten_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .q_empty_i    (q_empty),
    .q_op_i       (q_pop_op),
    .q_pop_o      (q_pop),
    .new_value_o  (new_value_o),
    .out_row_o    (out_row_o),
    .out_col_o    (out_col_o),
    .frame_done_o (frame_done_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i)
  );

endmodule

FILE: test/stencil_check.sv
// Result checker for the axis diffusion stencil: tracks the frame, predicts results and compares.
module stencil_check
  import dsten_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [COEFF_BITS-1:0]        cfg_data_i,
  input  logic signed [VALUE_BITS-1:0] cell_value_i,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic signed [VALUE_BITS-1:0] new_value_i,
  input  logic [IDX_BITS-1:0]          out_row_i,
  input  logic [IDX_BITS-1:0]          out_col_i,
  input  logic                         frame_done_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  output int                           fail_count_o,
  output int                           pending_o
);

  typedef logic signed [VALUE_BITS-1:0] cell_t;

  typedef struct packed {
    cell_t               value;
    logic [IDX_BITS-1:0] row;
    logic [IDX_BITS-1:0] col;
    logic                done;
  } stencil_res_t;

  localparam longint VAL_MAX = (longint'(1) <<< (VALUE_BITS - 1)) - 1;
  localparam longint VAL_MIN = -VAL_MAX - 1;

  // Expected results, oldest first
  stencil_res_t res_q[$];

  // Shadow of the block: line stores, row-mode cells, frame position, registers
  cell_t                   upper_row [MAX_GRID];
  cell_t                   held_row  [MAX_GRID];
  cell_t                   left_val;
  cell_t                   held_val;
  int unsigned             row_pos;
  int unsigned             col_pos;
  logic signed [COEFF_BITS-1:0] w_center;
  logic signed [COEFF_BITS-1:0] w_neighbor;
  dir_e                    axis;
  logic [IDX_BITS-1:0]     edge_len;
  int                      errs;

  // Weighted three-point sum, rounded half up and saturated
  function automatic cell_t weigh(cell_t before_v, cell_t center_v, cell_t after_v);
    longint acc;
    acc = longint'(center_v) * longint'(w_center)
        + longint'(w_neighbor) * (longint'(before_v) + longint'(after_v));
    acc = (acc + (longint'(1) <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
    if (acc > VAL_MAX) acc = VAL_MAX;
    if (acc < VAL_MIN) acc = VAL_MIN;
    return cell_t'(acc);
  endfunction

  task automatic add_result(cell_t v, int unsigned r, int unsigned c, logic d);
    stencil_res_t e;
    e.value = v;
    e.row   = IDX_BITS'(r);
    e.col   = IDX_BITS'(c);
    e.done  = d;
    res_q.push_back(e);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    stencil_res_t exp_r;
    cell_t        cur;
    int unsigned  n, r, c;
    logic         last_r, last_c;
    if (!rst_ni) begin
      res_q.delete();
      for (int j = 0; j < MAX_GRID; j++) begin
        upper_row[j] = '0;
        held_row[j]  = '0;
      end
      left_val     = '0;
      held_val     = '0;
      row_pos      = 0;
      col_pos      = 0;
      w_center     = 16'sd16384;
      w_neighbor   = '0;
      axis         = DIR_ROW;
      edge_len     = 6'd32;
      errs         = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // Result transfer: compare with the oldest expectation
      if (out_valid_i && out_ready_i) begin
        if (res_q.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("unexpected result: value %0d row %0d col %0d done %0b",
                     new_value_i, out_row_i, out_col_i, frame_done_i);
        end else begin
          exp_r = res_q.pop_front();
          if (exp_r.value !== new_value_i || exp_r.row !== out_row_i ||
              exp_r.col !== out_col_i || exp_r.done !== frame_done_i) begin
            errs++;
            if (errs <= 10)
              $display("mismatch: expected %0d r%0d c%0d done %0b, got %0d r%0d c%0d done %0b",
                       $signed(exp_r.value), exp_r.row, exp_r.col, exp_r.done,
                       new_value_i, out_row_i, out_col_i, frame_done_i);
          end
        end
      end

      // Register write; axis or size change restarts the frame
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_COEFF_CENTER:   w_center   = cfg_data_i;
          REG_COEFF_NEIGHBOR: w_neighbor = cfg_data_i;
          REG_DIRECTION: begin
            axis    = dir_e'(cfg_data_i[0]);
            row_pos = 0;
            col_pos = 0;
          end
          REG_GRID_SIZE: begin
            edge_len = cfg_data_i[IDX_BITS-1:0];
            row_pos  = 0;
            col_pos  = 0;
          end
          default: ;
        endcase
      end

      // Cell transfer: advance the shadow and queue what it yields
      if (in_valid_i && in_ready_i) begin
        cur = cell_value_i;
        n = (edge_len < 2) ? 2 : edge_len;
        r = (row_pos >= n) ? n - 1 : row_pos;
        c = (col_pos >= n) ? n - 1 : col_pos;
        last_r = (r == n - 1);
        last_c = (c == n - 1);
        if (axis == DIR_ROW) begin
          if (c == 0) begin
            left_val = '0;
            held_val = cur;
          end else begin
            add_result(weigh(left_val, held_val, cur), r, c - 1, 1'b0);
            left_val = held_val;
            held_val = cur;
          end
          // Row end: the last cell has no right neighbor
          if (last_c) add_result(weigh(left_val, cur, '0), r, c, last_r);
        end else begin
          if (r == 0) begin
            upper_row[c] = '0;
          end else begin
            add_result(weigh(upper_row[c], held_row[c], cur), r - 1, c, 1'b0);
            upper_row[c] = held_row[c];
          end
          held_row[c] = cur;
          // Frame end: flush the whole last row with no lower neighbor
          if (last_r && last_c)
            for (int j = 0; j < n; j++)
              add_result(weigh(upper_row[j], held_row[j], '0), r, j, j == n - 1);
        end
        if (last_c) begin
          col_pos = 0;
          row_pos = last_r ? 0 : r + 1;
        end else begin
          col_pos = c + 1;
          row_pos = r;
        end
      end

      fail_count_o <= errs;
      pending_o    <= res_q.size();
    end
  end

endmodule

FILE: test/tb.sv
// Testbench top for the axis diffusion stencil: stimulus, receiver, watchdog and verdict.
module tb;
  import dsten_pkg::*;

  localparam int unsigned RANDOM_CELLS = 300;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned STALL_LIMIT  = 3000;

  localparam logic signed [VALUE_BITS-1:0] CELL_MAX = 24'sh7FFFFF;
  localparam logic signed [VALUE_BITS-1:0] CELL_MIN = 24'sh800000;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [1:0]                   cfg_idx_i;
  logic [COEFF_BITS-1:0]        cfg_data_i;
  logic signed [VALUE_BITS-1:0] cell_value_i;
  logic                         in_valid_i;
  logic                         in_ready_o;
  logic signed [VALUE_BITS-1:0] new_value_o;
  logic [IDX_BITS-1:0]          out_row_o;
  logic [IDX_BITS-1:0]          out_col_o;
  logic                         frame_done_o;
  logic                         out_valid_o;
  logic                         out_ready_i;

  int          fail_count;
  int          pending;
  int unsigned cells_sent;
  int unsigned results_taken;
  int unsigned holds_done;
  int unsigned hold_left;
  int unsigned stall_cycles;
  int unsigned frame_edge;
  int unsigned frame_pos;
  int unsigned big_frames;

  axis_diffusion_stencil dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .cell_value_i (cell_value_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .new_value_o  (new_value_o),
    .out_row_o    (out_row_o),
    .out_col_o    (out_col_o),
    .frame_done_o (frame_done_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i)
  );

  stencil_check u_stencil_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .cell_value_i (cell_value_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .new_value_i  (new_value_o),
    .out_row_i    (out_row_o),
    .out_col_i    (out_col_o),
    .frame_done_i (frame_done_o),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Cell values: extremes, small magnitudes and full-range noise
  function automatic logic signed [VALUE_BITS-1:0] pick_cell();
    logic [31:0] word;
    word = $urandom;
    case ($urandom_range(9))
      0:       return CELL_MAX;
      1:       return CELL_MIN;
      2, 3:    return {{(VALUE_BITS-16){word[15]}}, word[15:0]};
      default: return word[VALUE_BITS-1:0];
    endcase
  endfunction

  // Weights: extremes, unity, diffusion-like small values and noise
  function automatic logic [COEFF_BITS-1:0] pick_coeff();
    logic [31:0] word;
    word = $urandom;
    case ($urandom_range(5))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'd16384;
      3:       return COEFF_BITS'($urandom_range(0, 8192));
      default: return word[COEFF_BITS-1:0];
    endcase
  endfunction

  // One cell transfer, with random gaps before it outside the busy window
  task automatic send_cell(input logic signed [VALUE_BITS-1:0] v);
    while ((cells_sent < 120 || cells_sent >= 200) && $urandom_range(99) < 17) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    cell_value_i <= v;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    cells_sent++;
    frame_pos = (frame_pos + 1) % (frame_edge * frame_edge);
  endtask

  // Drop valid, wait for every expected result, then let the pipeline empty
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [COEFF_BITS-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == REG_DIRECTION || idx == REG_GRID_SIZE) frame_pos = 0;
    if (idx == REG_GRID_SIZE)
      frame_edge = (data[IDX_BITS-1:0] < 2) ? 2 : data[IDX_BITS-1:0];
  endtask

  // Receiver: random stalls, a busy window, and two long hold-offs
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) results_taken++;
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (holds_done < 2 && results_taken >= 80 + 140 * holds_done && in_valid_i) begin
        out_ready_i <= 1'b0;
        hold_left = HOLD_CYCLES;
        holds_done++;
      end else if (results_taken >= 120 && results_taken < 200) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= 17);
      end
    end
  end

  // Watchdog: no transfer of any kind for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int unsigned         random_cells;
    int unsigned         want;
    logic [31:0]         word;
    logic [IDX_BITS-1:0] g;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_COEFF_CENTER;
    cfg_data_i    = '0;
    cell_value_i  = '0;
    in_valid_i    = 1'b0;
    cells_sent    = 0;
    results_taken = 0;
    holds_done    = 0;
    hold_left     = 0;
    stall_cycles  = 0;
    frame_edge    = 32;
    frame_pos     = 0;
    big_frames    = 0;
    random_cells  = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: unit weight along rows; the third cell is dropped by the restart
    send_cell(24'sd4096);
    send_cell(-24'sd4096);
    send_cell(24'sd123456);
    settle();

    // Extreme weights on a 2x2 grid (size 0 clamps to 2), saturating both ways
    write_reg(REG_COEFF_CENTER, 16'h7FFF);
    write_reg(REG_COEFF_NEIGHBOR, 16'h8000);
    write_reg(REG_DIRECTION, COEFF_BITS'(DIR_ROW));
    write_reg(REG_GRID_SIZE, '0);
    send_cell(CELL_MAX);
    send_cell(CELL_MIN);
    send_cell(-24'sd1);
    send_cell(24'sd0);
    settle();

    // Column mode on a grid of size 1 (clamps to 2), last-row flush
    write_reg(REG_GRID_SIZE, 16'd1);
    write_reg(REG_DIRECTION, COEFF_BITS'(DIR_COL));
    write_reg(REG_COEFF_CENTER, 16'h8000);
    write_reg(REG_COEFF_NEIGHBOR, 16'h7FFF);
    send_cell(CELL_MAX);
    send_cell(CELL_MAX);
    send_cell(CELL_MIN);
    send_cell(CELL_MIN);
    settle();

    // Rounding half up with the smallest center weight
    write_reg(REG_DIRECTION, COEFF_BITS'(DIR_ROW));
    write_reg(REG_COEFF_CENTER, 16'd1);
    write_reg(REG_COEFF_NEIGHBOR, '0);
    send_cell(24'sd8192);
    send_cell(-24'sd8192);
    send_cell(24'sd8191);
    send_cell(-24'sd8193);
    settle();

    // Weight change inside a frame, then a size write that restarts it
    write_reg(REG_GRID_SIZE, 16'd3);
    write_reg(REG_DIRECTION, COEFF_BITS'(DIR_COL));
    write_reg(REG_COEFF_CENTER, 16'd8192);
    write_reg(REG_COEFF_NEIGHBOR, 16'd4096);
    repeat (4) send_cell(pick_cell());
    settle();
    write_reg(REG_COEFF_CENTER, 16'd12000);
    repeat (2) send_cell(pick_cell());
    settle();
    write_reg(REG_GRID_SIZE, 16'd3);

    // Random phases: mostly whole small frames, some partial, a few at full size
    while (random_cells < RANDOM_CELLS) begin
      if ($urandom_range(1) == 1) write_reg(REG_COEFF_CENTER, pick_coeff());
      if ($urandom_range(1) == 1) write_reg(REG_COEFF_NEIGHBOR, pick_coeff());
      if ($urandom_range(3) == 0) begin
        word = $urandom;
        write_reg(REG_DIRECTION, word[COEFF_BITS-1:0]);
      end
      if (frame_edge == MAX_GRID || $urandom_range(3) == 0) begin
        if (big_frames < 2 && $urandom_range(7) == 0) begin
          g = IDX_BITS'(MAX_GRID);
          big_frames++;
        end else if ($urandom_range(9) == 0) begin
          g = IDX_BITS'($urandom_range(1));
        end else begin
          g = IDX_BITS'($urandom_range(2, 8));
        end
        word = $urandom;
        word[IDX_BITS-1:0] = g;
        write_reg(REG_GRID_SIZE, word[COEFF_BITS-1:0]);
      end
      if (frame_edge == MAX_GRID)
        want = MAX_GRID + $urandom_range(12);
      else if ($urandom_range(4) == 0)
        want = $urandom_range(1, frame_edge * frame_edge - frame_pos);
      else
        want = frame_edge * frame_edge - frame_pos;
      repeat (want) send_cell(pick_cell());
      random_cells += want;
      settle();
    end

    if (fail_count == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/dsten_pkg.sv
rtl/dsten_fifo.sv
rtl/dsten_front.sv
rtl/dsten_back.sv
rtl/axis_diffusion_stencil.sv
test/stencil_check.sv
test/tb.sv
